// ----- sv/sfr_pkg.sv -----
// Shared types, byte codes and the command decode for the serial frame receiver.
// Used by sfr_in_stage, sfr_core and serial_frame_receiver.
package sfr_pkg;

    localparam int FrameDepthDefault = 16;

    // Link-level byte codes
    localparam logic [7:0] SOF_BYTE   = 8'hB1;
    localparam logic [7:0] ACK_BYTE   = 8'h06;
    localparam logic [7:0] NACK_BYTE  = 8'h15;
    localparam logic [7:0] CHECK_INIT = 8'hFF;

    // Command ids and types
    localparam logic [7:0] ID_BOARD  = 8'h00;
    localparam logic [7:0] ID_LED    = 8'h01;
    localparam logic [7:0] ID_BUZZER = 8'h04;
    localparam logic [7:0] ID_TEMP   = 8'h84;
    localparam logic [7:0] ID_HUMID  = 8'h85;
    localparam logic [7:0] ID_LIGHT  = 8'h86;
    localparam logic [7:0] TY_BOARD  = 8'h00;
    localparam logic [7:0] TY_SENSOR = 8'h01;
    localparam logic [7:0] TY_SET    = 8'h02;
    localparam logic [7:0] SW_ON     = 8'hFF;

    // Result status codes
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_FRAME = 3'd1;
    localparam logic [2:0] ST_ACK   = 3'd2;
    localparam logic [2:0] ST_NACK  = 3'd3;
    localparam logic [2:0] ST_ERROR = 3'd4;

    // Decoded actions
    localparam logic [3:0] ACT_NONE       = 4'd0;
    localparam logic [3:0] ACT_BOARD      = 4'd1;
    localparam logic [3:0] ACT_LED_ON     = 4'd2;
    localparam logic [3:0] ACT_LED_OFF    = 4'd3;
    localparam logic [3:0] ACT_BUZZER_ON  = 4'd4;
    localparam logic [3:0] ACT_BUZZER_OFF = 4'd5;
    localparam logic [3:0] ACT_TEMP       = 4'd6;
    localparam logic [3:0] ACT_HUMID      = 4'd7;
    localparam logic [3:0] ACT_LIGHT      = 4'd8;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_DATA  = 2'd1,
        PH_CHECK = 2'd2
    } t_phase;

    // Map command id/type plus the switch bytes to an action
    function automatic logic [3:0] decode_action(input logic [7:0] id, input logic [7:0] ty,
                                                 input logic [7:0] b4, input logic [7:0] b5);
        logic [3:0] act;
        act = ACT_NONE;
        case (id)
            ID_BOARD:  if (ty == TY_BOARD) act = ACT_BOARD;
            ID_LED:    if (ty == TY_SET) act = (b4 == SW_ON) ? ACT_LED_ON : ACT_LED_OFF;
            ID_BUZZER: if (ty == TY_SET) act = (b5 == SW_ON) ? ACT_BUZZER_ON : ACT_BUZZER_OFF;
            ID_TEMP:   if (ty == TY_SENSOR) act = ACT_TEMP;
            ID_HUMID:  if (ty == TY_SENSOR) act = ACT_HUMID;
            ID_LIGHT:  if (ty == TY_SENSOR) act = ACT_LIGHT;
            default:   act = ACT_NONE;
        endcase
        return act;
    endfunction

endpackage

// ----- sv/sfr_in_stage.sv -----
// Input register of the serial frame receiver: holds one accepted byte for the parser.
// Depends on sfr_pkg.
module sfr_in_stage
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_take,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // Load a new item, or drop the held one once the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

// ----- sv/sfr_core.sv -----
// Frame parser of the serial frame receiver: phase, byte count, check value,
// the stored header bytes and the registered result. Depends on sfr_pkg.
module sfr_core
    import sfr_pkg::*;
#(
    parameter int FRAME_DEPTH = FrameDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_take,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_status,
    output logic [7:0] o_frame_length,
    output logic [7:0] o_command_id,
    output logic [7:0] o_command_type,
    output logic [3:0] o_action
);

    localparam int IW = $clog2(FRAME_DEPTH + 1);
    localparam int CW = (IW > 8) ? IW : 8;
    localparam logic [IW-1:0] IDX_FULL = IW'(FRAME_DEPTH);

    // Parser state
    t_phase        r_phase, n_phase;
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]    r_check, n_check;
    // Only bytes 0, 2, 3, 4 and 5 of the frame are ever read back
    logic [7:0]    r_b0, r_b2, r_b3, r_b4, r_b5;
    logic [7:0]    n_b0, n_b2, n_b3, n_b4, n_b5;

    // Result register
    logic          r_out_valid;
    logic [2:0]    r_status, n_status;
    logic [7:0]    r_len, r_cid, r_cty;
    logic [7:0]    n_len, n_cid, n_cty;
    logic [3:0]    r_act, n_act;

    logic          adv;
    logic [IW-1:0] idx_inc;

    assign adv     = i_valid && (!r_out_valid || i_ready);
    assign o_take  = adv;
    assign idx_inc = r_idx + IW'(1);

    // Next phase
    always_comb begin
        n_phase = PH_WAIT;
        case (r_phase)
            PH_DATA: begin
                if (r_idx < IDX_FULL) begin
                    n_phase = (CW'(idx_inc) == CW'(n_b0)) ? PH_CHECK : PH_DATA;
                end
            end
            PH_CHECK: n_phase = PH_WAIT;
            default:  n_phase = (i_byte == SOF_BYTE) ? PH_DATA : PH_WAIT;
        endcase
    end

    // Data path: store, count, check, and form the result
    always_comb begin
        n_idx    = r_idx;
        n_check  = r_check;
        n_b0     = r_b0;
        n_b2     = r_b2;
        n_b3     = r_b3;
        n_b4     = r_b4;
        n_b5     = r_b5;
        n_status = ST_NONE;
        n_len    = 8'd0;
        n_cid    = 8'd0;
        n_cty    = 8'd0;
        n_act    = ACT_NONE;
        case (r_phase)
            PH_DATA: begin
                if (r_idx < IDX_FULL) begin
                    if (r_idx == IW'(0)) n_b0 = i_byte;
                    if (r_idx == IW'(2)) n_b2 = i_byte;
                    if (r_idx == IW'(3)) n_b3 = i_byte;
                    if (r_idx == IW'(4)) n_b4 = i_byte;
                    if (r_idx == IW'(5)) n_b5 = i_byte;
                    if (r_idx != IW'(0)) n_check = r_check ^ i_byte;
                    n_idx = idx_inc;
                end else begin
                    n_status = ST_ERROR;
                end
            end
            PH_CHECK: begin
                if (i_byte == r_check) begin
                    n_status = ST_FRAME;
                    n_len    = r_b0;
                    n_cid    = r_b2;
                    n_cty    = r_b3;
                    n_act    = decode_action(r_b2, r_b3, r_b4, r_b5);
                end else begin
                    n_status = ST_ERROR;
                end
            end
            default: begin
                if (i_byte == SOF_BYTE) begin
                    n_idx   = '0;
                    n_check = CHECK_INIT;
                end else if (i_byte == ACK_BYTE) begin
                    n_status = ST_ACK;
                end else if (i_byte == NACK_BYTE) begin
                    n_status = ST_NACK;
                end else begin
                    n_status = ST_ERROR;
                end
            end
        endcase
    end

    // Advance parser state on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_idx   <= '0;
            r_check <= 8'd0;
            r_b0    <= 8'd0;
            r_b2    <= 8'd0;
            r_b3    <= 8'd0;
            r_b4    <= 8'd0;
            r_b5    <= 8'd0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_check <= n_check;
            r_b0    <= n_b0;
            r_b2    <= n_b2;
            r_b3    <= n_b3;
            r_b4    <= n_b4;
            r_b5    <= n_b5;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= n_status;
            r_len    <= n_len;
            r_cid    <= n_cid;
            r_cty    <= n_cty;
            r_act    <= n_act;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_frame_length = r_len;
    assign o_command_id   = r_cid;
    assign o_command_type = r_cty;
    assign o_action       = r_act;

    // Byte count never passes the buffer depth
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_FULL) else $error("byte index beyond frame depth");

    // A check byte always closes the frame
    a_check_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_phase == PH_CHECK |=> r_phase == PH_WAIT)
        else $error("frame not closed after check byte");

    // Start byte opens a fresh frame
    a_sof_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_phase == PH_WAIT && i_byte == SOF_BYTE
        |=> r_phase == PH_DATA && r_idx == '0 && r_check == CHECK_INIT)
        else $error("start byte did not open a frame");

    // Frame fields are zero unless a good frame is reported
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_FRAME
        |-> r_act == ACT_NONE && r_len == 8'd0 && r_cid == 8'd0 && r_cty == 8'd0)
        else $error("frame fields set without a good frame");

    // Only a start byte or a frame body byte leaves the status empty
    a_none_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_phase != PH_DATA && i_byte != SOF_BYTE |=> r_status != ST_NONE)
        else $error("empty status outside frame body");

endmodule

// ----- sv/serial_frame_receiver.sv -----
// Serial frame receiver: an accepted byte passes the input register, then the
// parser and result register; throughput one item per clock while the result
// is not stalled, set by the single-pass parser between the two registers.
// A stalled result still lets one more item wait in the input register.
// Synchronous active-low reset returns to waiting for a start byte and clears
// the byte count, check value, stored header bytes and both valid flags.
module serial_frame_receiver
    import sfr_pkg::*;
#(
    parameter int FRAME_DEPTH = FrameDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_status,
    output logic [7:0] o_frame_length,
    output logic [7:0] o_command_id,
    output logic [7:0] o_command_type,
    output logic [3:0] o_action
);

    logic       s1_valid;
    logic       s1_take;
    logic [7:0] s1_byte;

    // Input register
    sfr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .o_valid   (s1_valid),
        .i_take    (s1_take),
        .o_byte    (s1_byte)
    );

    // Parser and result register
    sfr_core #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s1_valid),
        .o_take         (s1_take),
        .i_byte         (s1_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_frame_length (o_frame_length),
        .o_command_id   (o_command_id),
        .o_command_type (o_command_type),
        .o_action       (o_action)
    );

endmodule
